// ===== rtl/core/ptm_pkg.sv =====
// package for the four-level page table manager
// types, codes and defaults shared by the controller, datapath and top level
`timescale 1ns / 1ps

package ptm_pkg;

   localparam int POOL_TABLES_DEFAULT = 64;
   localparam int ENTRY_BITS          = 9;
   localparam int FRAME_BITS          = 40;

   localparam logic [1:0] ACT_MAP    = 2'd0;
   localparam logic [1:0] ACT_UNMAP  = 2'd1;
   localparam logic [1:0] ACT_XLATE  = 2'd2;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FAIL  = 2'd1;
   localparam logic [1:0] STAT_NOMAP = 2'd2;

   localparam logic [1:0] LVL_TOP    = 2'd0;
   localparam logic [1:0] LVL_LEAF   = 2'd3;

   localparam logic [11:0] LINK_FLAGS = 12'h003;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_CLEAR,
      ST_LINK
   } ptm_state_type;

   typedef struct packed {
      logic       clr_top;
      logic       load;
      logic       rd;
      logic       descend;
      logic       alloc_start;
      logic       clr_pool;
      logic       link;
      logic       leaf;
      logic       fin;
      logic       xlate_ok;
      logic [1:0] status;
   } ptm_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] lvl;
      logic       present;
      logic       link_ok;
      logic       pool_full;
      logic       clr_last;
   } ptm_stat_type;

endpackage

// ===== rtl/core/ptm_ctrl.sv =====
// controller state machine of the page table manager
// sequences clearing, walk, allocation and leaf update; uses ptm_pkg
`timescale 1ns / 1ps

module ptm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_action,
   input  ptm_pkg::ptm_stat_type stat,
   output ptm_pkg::ptm_cmd_type  cmd,
   output logic                  busy
);

   ptm_pkg::ptm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptm_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = ptm_pkg::STAT_DONE;
      unique case (state_ff)
         ptm_pkg::ST_INIT: begin
            cmd.clr_top = 1'b1;
            if (stat.clr_last) begin
               state_in = ptm_pkg::ST_IDLE;
            end
         end
         ptm_pkg::ST_IDLE: begin
            if (start) begin
               if (req_action == ptm_pkg::ACT_MAP || req_action == ptm_pkg::ACT_UNMAP ||
                   req_action == ptm_pkg::ACT_XLATE) begin
                  cmd.load = 1'b1;
                  state_in = ptm_pkg::ST_READ;
               end else begin
                  cmd.fin = 1'b1;
               end
            end
         end
         ptm_pkg::ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ptm_pkg::ST_CHECK;
         end
         ptm_pkg::ST_CHECK: begin
            if (stat.lvl == ptm_pkg::LVL_LEAF) begin
               cmd.leaf = 1'b1;
               cmd.fin  = 1'b1;
               state_in = ptm_pkg::ST_IDLE;
               if (stat.action == ptm_pkg::ACT_XLATE) begin
                  cmd.xlate_ok = stat.present;
                  cmd.status   = stat.present ? ptm_pkg::STAT_DONE : ptm_pkg::STAT_NOMAP;
               end
            end else if (stat.present) begin
               if (stat.link_ok) begin
                  cmd.descend = 1'b1;
                  state_in    = ptm_pkg::ST_READ;
               end else begin
                  cmd.fin  = 1'b1;
                  state_in = ptm_pkg::ST_IDLE;
                  if (stat.action == ptm_pkg::ACT_MAP) begin
                     cmd.status = ptm_pkg::STAT_FAIL;
                  end else if (stat.action == ptm_pkg::ACT_XLATE) begin
                     cmd.status = ptm_pkg::STAT_NOMAP;
                  end
               end
            end else if (stat.action != ptm_pkg::ACT_MAP) begin
               cmd.fin  = 1'b1;
               state_in = ptm_pkg::ST_IDLE;
               if (stat.action == ptm_pkg::ACT_XLATE) begin
                  cmd.status = ptm_pkg::STAT_NOMAP;
               end
            end else if (stat.pool_full) begin
               cmd.fin    = 1'b1;
               cmd.status = ptm_pkg::STAT_FAIL;
               state_in   = ptm_pkg::ST_IDLE;
            end else begin
               cmd.alloc_start = 1'b1;
               state_in        = ptm_pkg::ST_CLEAR;
            end
         end
         ptm_pkg::ST_CLEAR: begin
            cmd.clr_pool = 1'b1;
            if (stat.clr_last) begin
               state_in = ptm_pkg::ST_LINK;
            end
         end
         ptm_pkg::ST_LINK: begin
            cmd.link = 1'b1;
            state_in = ptm_pkg::ST_READ;
         end
         default: begin
            state_in = ptm_pkg::ST_INIT;
         end
      endcase
   end

   assign busy = (state_ff != ptm_pkg::ST_IDLE);

endmodule

// ===== rtl/core/ptm_datapath.sv =====
// datapath of the page table manager: top table and pool memories,
// request registers, counters and result registers; uses ptm_pkg
`timescale 1ns / 1ps

module ptm_datapath #(
   parameter int POOL_TABLES = ptm_pkg::POOL_TABLES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ptm_pkg::ptm_cmd_type  cmd,
   output ptm_pkg::ptm_stat_type stat,
   input  logic [1:0]            req_action,
   input  logic [47:0]           req_virt_addr,
   input  logic [51:0]           req_phys_addr,
   input  logic [11:0]           req_flags_low,
   input  logic [11:0]           req_flags_high,
   input  logic                  cfg_we,
   input  logic [39:0]           cfg_wdata,
   output logic [39:0]           cfg_base,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic [51:0]           rsp_phys_result,
   output logic [15:0]           rsp_mapped_count,
   output logic [6:0]            rsp_tables_used
);

   localparam int IW    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
   localparam int CW    = $clog2(POOL_TABLES + 1);
   localparam int AW    = IW + ptm_pkg::ENTRY_BITS;
   localparam int DEPTH = POOL_TABLES * (2 ** ptm_pkg::ENTRY_BITS);
   localparam int TOPD  = 2 ** ptm_pkg::ENTRY_BITS;

   logic [63:0] top_mem [TOPD];
   logic [63:0] pool_mem [DEPTH];

   logic [1:0]  act_ff;
   logic [47:0] va_ff;
   logic [51:0] pa_ff;
   logic [11:0] fl_ff, fh_ff;
   logic [1:0]  lvl_ff;
   logic [IW-1:0] idx_ff;
   logic [CW-1:0] alloc_ff;
   logic [15:0] cnt_ff, cnt_in;
   logic [8:0]  clr_ff;
   logic [39:0] base_ff;
   logic [63:0] top_q_ff, pool_q_ff;
   logic        strobe_ff;
   logic [1:0]  status_ff;
   logic [51:0] phys_ff;
   logic [15:0] mapped_ff;
   logic [CW-1:0] used_ff;

   logic [8:0]  vbits;
   logic [63:0] entry;
   logic [39:0] off;
   logic [39:0] link_frame;
   logic [63:0] link_entry;
   logic [63:0] leaf_entry;
   logic [AW-1:0] pool_waddr;
   logic [63:0] pool_wdata;
   logic        pool_we;
   logic [8:0]  top_waddr;
   logic [63:0] top_wdata;
   logic        top_we;
   logic [31:0] used_wide;

   always_comb begin
      unique case (lvl_ff)
         2'd0:    vbits = va_ff[47:39];
         2'd1:    vbits = va_ff[38:30];
         2'd2:    vbits = va_ff[29:21];
         default: vbits = va_ff[20:12];
      endcase
   end

   assign entry      = (lvl_ff == ptm_pkg::LVL_TOP) ? top_q_ff : pool_q_ff;
   assign off        = entry[51:12] - base_ff;
   assign link_frame = base_ff + 40'(alloc_ff);
   assign link_entry = {12'h000, link_frame, ptm_pkg::LINK_FLAGS};
   assign leaf_entry = {fh_ff, pa_ff[51:12], fl_ff};

   assign stat.action    = act_ff;
   assign stat.lvl       = lvl_ff;
   assign stat.present   = entry[0];
   assign stat.link_ok   = off < 40'(alloc_ff);
   assign stat.pool_full = alloc_ff >= CW'(POOL_TABLES);
   assign stat.clr_last  = (clr_ff == 9'h1FF);

   always_comb begin
      pool_we    = 1'b0;
      pool_waddr = {idx_ff, vbits};
      pool_wdata = 64'd0;
      if (cmd.clr_pool) begin
         pool_we    = 1'b1;
         pool_waddr = {alloc_ff[IW-1:0], clr_ff};
      end else if (cmd.link && lvl_ff != ptm_pkg::LVL_TOP) begin
         pool_we    = 1'b1;
         pool_wdata = link_entry;
      end else if (cmd.leaf && act_ff != ptm_pkg::ACT_XLATE) begin
         pool_we    = 1'b1;
         pool_wdata = (act_ff == ptm_pkg::ACT_MAP) ? leaf_entry : 64'd0;
      end
   end

   always_comb begin
      top_we    = 1'b0;
      top_waddr = va_ff[47:39];
      top_wdata = 64'd0;
      if (cmd.clr_top) begin
         top_we    = 1'b1;
         top_waddr = clr_ff;
      end else if (cmd.link && lvl_ff == ptm_pkg::LVL_TOP) begin
         top_we    = 1'b1;
         top_wdata = link_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem[pool_waddr] <= pool_wdata;
      end
      if (cmd.rd) begin
         pool_q_ff <= pool_mem[{idx_ff, vbits}];
      end
   end

   always_ff @(posedge clock) begin
      if (top_we) begin
         top_mem[top_waddr] <= top_wdata;
      end
      if (cmd.rd) begin
         top_q_ff <= top_mem[va_ff[47:39]];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.leaf) begin
         if (act_ff == ptm_pkg::ACT_MAP && !entry[0] && cnt_ff != 16'hFFFF) begin
            cnt_in = cnt_ff + 16'd1;
         end else if (act_ff == ptm_pkg::ACT_UNMAP && entry[0] && cnt_ff != 16'd0) begin
            cnt_in = cnt_ff - 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff    <= ptm_pkg::LVL_TOP;
         alloc_ff  <= '0;
         cnt_ff    <= 16'd0;
         clr_ff    <= 9'd0;
         base_ff   <= 40'd0;
         strobe_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         strobe_ff <= cmd.fin;
         if (cfg_we) begin
            base_ff <= cfg_wdata;
         end
         if (cmd.load) begin
            lvl_ff <= ptm_pkg::LVL_TOP;
         end else if (cmd.descend || cmd.link) begin
            lvl_ff <= lvl_ff + 2'd1;
         end
         if (cmd.link) begin
            alloc_ff <= alloc_ff + CW'(1);
         end
         if (cmd.alloc_start) begin
            clr_ff <= 9'd0;
         end else if (cmd.clr_top || cmd.clr_pool) begin
            clr_ff <= clr_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         va_ff  <= req_virt_addr;
         pa_ff  <= req_phys_addr;
         fl_ff  <= req_flags_low;
         fh_ff  <= req_flags_high;
      end
      if (cmd.descend) begin
         idx_ff <= off[IW-1:0];
      end else if (cmd.link) begin
         idx_ff <= alloc_ff[IW-1:0];
      end
      if (cmd.fin) begin
         status_ff <= cmd.status;
         phys_ff   <= cmd.xlate_ok ? {entry[51:12], va_ff[11:0]} : 52'd0;
         mapped_ff <= cnt_in;
         used_ff   <= alloc_ff;
      end
   end

   assign used_wide        = 32'(used_ff);
   assign cfg_base         = base_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_phys_result  = phys_ff;
   assign rsp_mapped_count = mapped_ff;
   assign rsp_tables_used  = used_wide[6:0];

endmodule

// ===== rtl/core/four_level_page_table_manager.sv =====
// top level of the four-level page table manager
// joins ptm_ctrl and ptm_datapath and decodes the register port; uses ptm_pkg
//
// usage: a request (map, unmap or translate of one 4 KiB page) is taken at a
// rising edge with start high and busy low. Its result is registered: it appears
// in the cycle after the request completes, on the rsp_ ports for exactly one
// cycle with rsp_strobe high; the receiver cannot stall, it must take it then.
// walk: each table level takes a registered read and a check (four levels);
// each table allocated on a map adds a pass that clears its 512 entries plus
// a link step. Throughput is one request at a time: the next request is taken
// in the cycle the result is shown.
// the pace is set by the registered table memory read, one per level.
// reset (synchronous, active high) starts a pass that clears the 512 entries
// of the top table; busy stays high until it ends. Pool tables hold no reset
// value and are cleared only when allocated.
// register: pool_base_frame at byte address 0, 64-bit data, written during
// the access phase of an APB write; pready is always high.
`timescale 1ns / 1ps

module four_level_page_table_manager #(
   parameter int POOL_TABLES = ptm_pkg::POOL_TABLES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [47:0] req_virt_addr,
   input  logic [51:0] req_phys_addr,
   input  logic [11:0] req_flags_low,
   input  logic [11:0] req_flags_high,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [51:0] rsp_phys_result,
   output logic [15:0] rsp_mapped_count,
   output logic [6:0]  rsp_tables_used,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   ptm_pkg::ptm_cmd_type  cmd;
   ptm_pkg::ptm_stat_type stat;
   logic                  cfg_we;
   logic [39:0]           cfg_base;

   assign cfg_we = psel && penable && pwrite && !paddr[3];
   assign prdata = paddr[3] ? 64'd0 : {24'd0, cfg_base};
   assign pready = 1'b1;

   ptm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   ptm_datapath #(
      .POOL_TABLES (POOL_TABLES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_action),
      .req_virt_addr    (req_virt_addr),
      .req_phys_addr    (req_phys_addr),
      .req_flags_low    (req_flags_low),
      .req_flags_high   (req_flags_high),
      .cfg_we           (cfg_we),
      .cfg_wdata        (pwdata[39:0]),
      .cfg_base         (cfg_base),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_phys_result  (rsp_phys_result),
      .rsp_mapped_count (rsp_mapped_count),
      .rsp_tables_used  (rsp_tables_used)
   );

endmodule

// ===== rtl/core/ptm_checker.sv =====
// port checker for the page table manager, bound to the top level
// watches only top-level ports; uses no package
`timescale 1ns / 1ps

module ptm_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic [6:0]  rsp_tables_used,
   input logic        pready
);

   // result shows only once the request has finished
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // a result strobe only follows a busy cycle or a request taken
   a_strobe_after: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy) || $past(start))
      else $error("result strobe without request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_status != 2'd3)
      else $error("bad status code");

   // allocated tables never go back; checked on results in consecutive cycles
   a_used_grows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(rsp_strobe) && !$past(reset) |->
         rsp_tables_used >= $past(rsp_tables_used))
      else $error("tables used went down");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind four_level_page_table_manager ptm_checker u_ptm_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_tables_used (rsp_tables_used),
   .pready          (pready)
);
